/* src/stfp_pkg.sv */
package stfp_pkg;

  localparam int MAX_TOKEN_CHARS = 14;
  localparam int NUM_VALUES      = 5;

  localparam int NUM_OUT   = 5;
  localparam int OUT_W     = 15;
  localparam int MAG_W     = 17;
  localparam int QDEPTH    = 2;

  localparam logic [OUT_W-1:0] FULL_SCALE = 15'd18000;
  localparam logic [MAG_W-1:0] MAG_MAX    = 17'd131071;

  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_END   = 8'h2A;
  localparam logic [7:0] CH_SEP   = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    CLS_START,
    CLS_END,
    CLS_SEP,
    CLS_MINUS,
    CLS_POINT,
    CLS_DIGIT,
    CLS_OTHER
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [3:0] digit;
  } item_t;

endpackage

/* src/stfp_front.sv */
module stfp_front (
  input  logic                 in_valid,
  input  logic [7:0]           in_rx_byte,
  output logic                 push,
  output stfp_pkg::item_t      item
);

  stfp_pkg::cls_t cls;
  logic [7:0]     diff;

  always_comb begin
    diff = in_rx_byte - stfp_pkg::CH_ZERO;
    priority if (in_rx_byte == stfp_pkg::CH_START) begin
      cls = stfp_pkg::CLS_START;
    end else if (in_rx_byte == stfp_pkg::CH_END) begin
      cls = stfp_pkg::CLS_END;
    end else if (in_rx_byte == stfp_pkg::CH_SEP) begin
      cls = stfp_pkg::CLS_SEP;
    end else if (in_rx_byte == stfp_pkg::CH_MINUS) begin
      cls = stfp_pkg::CLS_MINUS;
    end else if (in_rx_byte == stfp_pkg::CH_POINT) begin
      cls = stfp_pkg::CLS_POINT;
    end else if (in_rx_byte >= stfp_pkg::CH_ZERO && in_rx_byte <= stfp_pkg::CH_NINE) begin
      cls = stfp_pkg::CLS_DIGIT;
    end else begin
      cls = stfp_pkg::CLS_OTHER;
    end
  end

  assign item.cls   = cls;
  assign item.digit = diff[3:0];
  // bytes that never affect the parse are dropped here
  assign push = in_valid && (cls != stfp_pkg::CLS_OTHER);

endmodule

/* src/stfp_queue.sv */
module stfp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  stfp_pkg::item_t push_item,
  output logic            full,
  output logic            head_valid,
  output stfp_pkg::item_t head_item,
  input  logic            pop
);

  localparam int PW = (stfp_pkg::QDEPTH > 1) ? $clog2(stfp_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(stfp_pkg::QDEPTH + 1);

  stfp_pkg::item_t mem_r [stfp_pkg::QDEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full       = (cnt_r == CW'(stfp_pkg::QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(stfp_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(stfp_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* src/stfp_back.sv */
module stfp_back #(
  parameter int MAX_TOKEN_CHARS = stfp_pkg::MAX_TOKEN_CHARS,
  parameter int NUM_VALUES      = stfp_pkg::NUM_VALUES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       head_valid,
  input  stfp_pkg::item_t            head_item,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [stfp_pkg::OUT_W-1:0] out_target_a,
  output logic [stfp_pkg::OUT_W-1:0] out_target_b,
  output logic [stfp_pkg::OUT_W-1:0] out_target_c,
  output logic [stfp_pkg::OUT_W-1:0] out_target_d,
  output logic [stfp_pkg::OUT_W-1:0] out_target_e
);

  localparam int TCW   = $clog2(MAX_TOKEN_CHARS + 1);
  localparam int VCW   = $clog2(NUM_VALUES + 1);
  localparam int IW    = (NUM_VALUES > 1) ? $clog2(NUM_VALUES) : 1;
  localparam int MAG_W = stfp_pkg::MAG_W;
  localparam int OUT_W = stfp_pkg::OUT_W;
  localparam int SUM_W = MAG_W + 5;

  logic             in_frame_r, in_frame_nxt;
  logic [VCW-1:0]   value_count_r, value_count_nxt;
  logic [TCW-1:0]   token_chars_r, token_chars_nxt;
  logic             token_negative_r, token_negative_nxt;
  logic             token_point_seen_r, token_point_seen_nxt;
  logic             token_stopped_r, token_stopped_nxt;
  logic [1:0]       token_frac_digits_r, token_frac_digits_nxt;
  logic [MAG_W-1:0] token_magnitude_r, token_magnitude_nxt;
  logic [OUT_W-1:0] held_r [NUM_VALUES];

  logic             out_valid_r;
  logic [OUT_W-1:0] tgt_r [stfp_pkg::NUM_OUT];

  logic             step;
  logic             store;
  logic [OUT_W-1:0] store_val;
  logic             emit;
  logic [SUM_W-1:0] sum;
  logic [OUT_W-1:0] eff [stfp_pkg::NUM_OUT];

  assign pop  = head_valid && (!out_valid_r || !out_stall);
  assign step = pop;

  // value of the open token as it would be stored
  always_comb begin
    if (token_negative_r) begin
      store_val = '0;
    end else if (token_magnitude_r > MAG_W'(stfp_pkg::FULL_SCALE)) begin
      store_val = stfp_pkg::FULL_SCALE;
    end else begin
      store_val = token_magnitude_r[OUT_W-1:0];
    end
  end

  // digit accumulate: times ten plus d*100 before the point, d*10 or d after
  always_comb begin
    if (!token_point_seen_r) begin
      sum = (SUM_W'(token_magnitude_r) << 3) + (SUM_W'(token_magnitude_r) << 1)
            + (SUM_W'(head_item.digit) * SUM_W'(100));
    end else if (token_frac_digits_r == 2'd0) begin
      sum = SUM_W'(token_magnitude_r) + (SUM_W'(head_item.digit) * SUM_W'(10));
    end else begin
      sum = SUM_W'(token_magnitude_r) + SUM_W'(head_item.digit);
    end
  end

  always_comb begin
    in_frame_nxt          = in_frame_r;
    value_count_nxt       = value_count_r;
    token_chars_nxt       = token_chars_r;
    token_negative_nxt    = token_negative_r;
    token_point_seen_nxt  = token_point_seen_r;
    token_stopped_nxt     = token_stopped_r;
    token_frac_digits_nxt = token_frac_digits_r;
    token_magnitude_nxt   = token_magnitude_r;
    store                 = 1'b0;
    emit                  = 1'b0;

    if (step && (head_item.cls == stfp_pkg::CLS_START || in_frame_r)) begin
      unique case (head_item.cls)
        stfp_pkg::CLS_START: begin
          in_frame_nxt          = 1'b1;
          value_count_nxt       = '0;
          token_chars_nxt       = '0;
          token_negative_nxt    = 1'b0;
          token_point_seen_nxt  = 1'b0;
          token_stopped_nxt     = 1'b0;
          token_frac_digits_nxt = '0;
          token_magnitude_nxt   = '0;
        end
        stfp_pkg::CLS_END, stfp_pkg::CLS_SEP: begin
          store = (token_chars_r != '0) && (value_count_r < VCW'(NUM_VALUES));
          if (store) begin
            value_count_nxt = value_count_r + 1'b1;
          end
          if (store || head_item.cls == stfp_pkg::CLS_END) begin
            token_chars_nxt       = '0;
            token_negative_nxt    = 1'b0;
            token_point_seen_nxt  = 1'b0;
            token_stopped_nxt     = 1'b0;
            token_frac_digits_nxt = '0;
            token_magnitude_nxt   = '0;
          end
          if (head_item.cls == stfp_pkg::CLS_END) begin
            emit            = (value_count_r + VCW'(store)) == VCW'(NUM_VALUES);
            in_frame_nxt    = 1'b0;
            value_count_nxt = '0;
          end
        end
        stfp_pkg::CLS_MINUS, stfp_pkg::CLS_POINT, stfp_pkg::CLS_DIGIT: begin
          if (token_chars_r < TCW'(MAX_TOKEN_CHARS)) begin
            token_chars_nxt = token_chars_r + 1'b1;
            if (!token_stopped_r) begin
              if (head_item.cls == stfp_pkg::CLS_MINUS) begin
                if (token_chars_r == '0) begin
                  token_negative_nxt = 1'b1;
                end else begin
                  token_stopped_nxt = 1'b1;
                end
              end else if (head_item.cls == stfp_pkg::CLS_POINT) begin
                if (token_point_seen_r) begin
                  token_stopped_nxt = 1'b1;
                end else begin
                  token_point_seen_nxt = 1'b1;
                end
              end else if (!token_point_seen_r || token_frac_digits_r != 2'd2) begin
                token_magnitude_nxt = (sum > SUM_W'(stfp_pkg::MAG_MAX)) ?
                                      stfp_pkg::MAG_MAX : sum[MAG_W-1:0];
                if (token_point_seen_r) begin
                  token_frac_digits_nxt = token_frac_digits_r + 1'b1;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // held values with the one stored by this very '*' bypassed in
  for (genvar j = 0; j < stfp_pkg::NUM_OUT; j++) begin : g_eff
    if (j < NUM_VALUES) begin : g_held
      assign eff[j] = (store && value_count_r == VCW'(j)) ? store_val : held_r[j];
    end else begin : g_zero
      assign eff[j] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r          <= 1'b0;
      value_count_r       <= '0;
      token_chars_r       <= '0;
      token_negative_r    <= 1'b0;
      token_point_seen_r  <= 1'b0;
      token_stopped_r     <= 1'b0;
      token_frac_digits_r <= '0;
      token_magnitude_r   <= '0;
      out_valid_r         <= 1'b0;
    end else begin
      in_frame_r          <= in_frame_nxt;
      value_count_r       <= value_count_nxt;
      token_chars_r       <= token_chars_nxt;
      token_negative_r    <= token_negative_nxt;
      token_point_seen_r  <= token_point_seen_nxt;
      token_stopped_r     <= token_stopped_nxt;
      token_frac_digits_r <= token_frac_digits_nxt;
      token_magnitude_r   <= token_magnitude_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      held_r[value_count_r[IW-1:0]] <= store_val;
    end
    if (emit) begin
      tgt_r[0] <= eff[0];
      tgt_r[1] <= eff[1];
      tgt_r[2] <= eff[2];
      tgt_r[3] <= stfp_pkg::FULL_SCALE - eff[3];
      tgt_r[4] <= stfp_pkg::FULL_SCALE - eff[4];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_target_a = tgt_r[0];
  assign out_target_b = tgt_r[1];
  assign out_target_c = tgt_r[2];
  assign out_target_d = tgt_r[3];
  assign out_target_e = tgt_r[4];

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    value_count_r <= VCW'(NUM_VALUES))
    else $error("value count past limit");

  a_chars_range: assert property (@(posedge clk) disable iff (!rst_n)
    token_chars_r <= TCW'(MAX_TOKEN_CHARS))
    else $error("token length past limit");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> (value_count_r == '0 && token_chars_r == '0))
    else $error("token or count left over outside a frame");

  a_frac_point: assert property (@(posedge clk) disable iff (!rst_n)
    (token_frac_digits_r != 2'd0) |-> token_point_seen_r)
    else $error("fraction digits without a point");

  a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !pop)
    else $error("parser advanced over a pending result");

endmodule

/* src/servo_target_frame_parser_top.sv */
// Servo target frame parser: takes one received byte per transaction and
// parses frames "$v,v,v,v,v*" into five servo targets in hundredths of a
// degree (0..18000), the fourth and fifth mirrored as 18000 minus the value.
// A transaction is accepted every clock cycle while in_stall is low; the
// rate is set by the per-byte token update in the parse stage. A
// classifier feeds a two-entry queue ahead of the parse stage, and the
// result sits in an output register, so bytes keep flowing while a
// result waits to be taken; in_stall rises only once the queue has
// filled behind a stalled result. A frame's result is registered onto
// out_valid once its '*' byte has passed through the queue and been
// taken by the parse stage, which a waiting result can hold. Bytes other
// than '$', '*', ',', digits, '.' and '-' are discarded at the input.
module servo_target_frame_parser_top #(
  parameter int MAX_TOKEN_CHARS = stfp_pkg::MAX_TOKEN_CHARS,
  parameter int NUM_VALUES      = stfp_pkg::NUM_VALUES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_rx_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [stfp_pkg::OUT_W-1:0] out_target_a,
  output logic [stfp_pkg::OUT_W-1:0] out_target_b,
  output logic [stfp_pkg::OUT_W-1:0] out_target_c,
  output logic [stfp_pkg::OUT_W-1:0] out_target_d,
  output logic [stfp_pkg::OUT_W-1:0] out_target_e
);

  logic            push;
  stfp_pkg::item_t push_item;
  logic            q_full;
  logic            head_valid;
  stfp_pkg::item_t head_item;
  logic            pop;

  assign in_stall = q_full;

  stfp_front u_front (
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .push       (push),
    .item       (push_item)
  );

  stfp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop)
  );

  stfp_back #(
    .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS),
    .NUM_VALUES      (NUM_VALUES)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (head_valid),
    .head_item    (head_item),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_target_a (out_target_a),
    .out_target_b (out_target_b),
    .out_target_c (out_target_c),
    .out_target_d (out_target_d),
    .out_target_e (out_target_e)
  );

endmodule
